// ===== src/mqta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-queue timestamp aligner package
// Shared field widths, command and status codes and the request and result structs.
// ----------------------------------------------------------------------------
package mqta_pkg;

  localparam int STAMP_W = 48;
  localparam int TAG_W   = 16;
  localparam int TOL_W   = 32;
  localparam int ENTRY_W = STAMP_W + TAG_W;

  localparam logic [TOL_W-1:0] TOL_RESET = 32'd40000;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_SYNC = 1'b1;

  localparam logic [1:0] ST_PUSH_OK   = 2'd0;
  localparam logic [1:0] ST_PUSH_FULL = 2'd1;
  localparam logic [1:0] ST_SYNC_ITEM = 2'd2;
  localparam logic [1:0] ST_SYNC_FAIL = 2'd3;

  typedef struct packed {
    logic               command;
    logic [1:0]         camera;
    logic [STAMP_W-1:0] stamp;
    logic [TAG_W-1:0]   tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         source_camera;
    logic [STAMP_W-1:0] entry_stamp;
    logic [TAG_W-1:0]   entry_tag;
    logic [STAMP_W-1:0] sync_stamp;
    logic               last;
  } out_item_t;

endpackage

// ===== src/mqta_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Queue entry store
// Single write, single read memory holding every camera queue's entries.
// ----------------------------------------------------------------------------
module mqta_store #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [mqta_pkg::ENTRY_W-1:0] wdata,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [mqta_pkg::ENTRY_W-1:0] rdata
);

  logic [mqta_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/multi_queue_timestamp_aligner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-queue timestamp aligner
// Per-camera timestamp queues in one shared memory, with push and sync.
// ----------------------------------------------------------------------------
// A push's result is registered from S_PUSH once the output is free.
// A sync checks for empty queues, reads the head and tail of every queue through the
// single read port of the queue memory, then emits one result a cycle while the output
// is not stalled; drops add a reread of the heads. One request is processed at a time.
// Reset clears pointers and fill counts and sets tolerance to 40000.
module multi_queue_timestamp_aligner #(
  parameter int NUM_CAMERAS = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  mqta_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output mqta_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mqta_pkg::TOL_W-1:0]       cfg_data
);

  localparam int CW  = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;
  localparam int CIW = (CW > 2) ? CW : 2;
  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int AW  = $clog2(NUM_CAMERAS * QUEUE_DEPTH);
  localparam int KW  = $clog2(2 * NUM_CAMERAS + 1);
  localparam int SW  = mqta_pkg::STAMP_W;
  localparam int TW  = mqta_pkg::TAG_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PUSH  = 3'd1;
  localparam logic [2:0] S_EMPTY = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_DROP  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;
  localparam logic [2:0] S_FAIL  = 3'd7;

  logic [2:0]                  state_r, state_nxt;
  mqta_pkg::in_item_t          item_r, item_nxt;
  logic [mqta_pkg::TOL_W-1:0]  tol_r;
  logic                        pass2_r, pass2_nxt;
  logic                        c1_r, c1_nxt;
  logic                        c2_r, c2_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [KW-1:0]               rd_cnt_r, rd_cnt_nxt;
  logic                        cap_v_r, cap_v_nxt;
  logic                        cap_tail_r, cap_tail_nxt;
  logic                        cap_last_r, cap_last_nxt;
  logic [CW-1:0]               cap_cam_r, cap_cam_nxt;
  logic [SW-1:0]               mn_r, mn_nxt;
  logic [SW-1:0]               mx_r, mx_nxt;
  logic [SW-1:0]               mint_r, mint_nxt;
  logic [SW-1:0]               sync_r, sync_nxt;
  logic                        out_valid_r, out_valid_nxt;
  mqta_pkg::out_item_t         out_r, out_nxt;

  logic [PW-1:0] head_ptr_r [NUM_CAMERAS];
  logic [PW-1:0] head_ptr_nxt [NUM_CAMERAS];
  logic [PW-1:0] tail_ptr_r [NUM_CAMERAS];
  logic [PW-1:0] tail_ptr_nxt [NUM_CAMERAS];
  logic [FW-1:0] fill_r [NUM_CAMERAS];
  logic [FW-1:0] fill_nxt [NUM_CAMERAS];
  logic [SW-1:0] head_st_r [NUM_CAMERAS];
  logic [SW-1:0] head_st_nxt [NUM_CAMERAS];
  logic [TW-1:0] head_tag_r [NUM_CAMERAS];
  logic [TW-1:0] head_tag_nxt [NUM_CAMERAS];
  logic [SW-1:0] tail_st_r [NUM_CAMERAS];
  logic [SW-1:0] tail_st_nxt [NUM_CAMERAS];

  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [mqta_pkg::ENTRY_W-1:0]   mem_wdata;
  logic [AW-1:0]                  mem_raddr;
  logic [mqta_pkg::ENTRY_W-1:0]   mem_rdata;
  logic [SW-1:0]                  rd_stamp;
  logic [TW-1:0]                  rd_tag;

  logic                ofree;
  logic                any_empty;
  logic                cam_ok;
  logic [CIW-1:0]      cam_ext;
  logic [CW-1:0]       cam_idx;
  logic [CIW-1:0]      cnt_ext;
  logic [KW-1:0]       rd_total;
  logic [CW-1:0]       rd_cam;
  logic                rd_is_tail;
  logic [SW:0]         mn_tol;
  logic [SW:0]         mint_tol;
  logic [SW:0]         mx_e;
  logic [SW:0]         hd_tol;
  logic [SW:0]         tl_tol;
  logic [SW:0]         mid_sum;
  logic                drop_pop;
  logic [FW-1:0]       fill_after;

  function automatic logic [AW-1:0] qaddr(input logic [CW-1:0] c, input logic [PW-1:0] p);
    return AW'(c) * AW'(QUEUE_DEPTH) + AW'(p);
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? PW'(QUEUE_DEPTH - 1) : p - PW'(1);
  endfunction

  mqta_store #(
    .DEPTH  (NUM_CAMERAS * QUEUE_DEPTH),
    .ADDR_W (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_stamp  = mem_rdata[mqta_pkg::ENTRY_W-1:TW];
  assign rd_tag    = mem_rdata[TW-1:0];
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;
  assign ofree     = !out_valid_r || !out_stall;

  assign cam_ext  = CIW'(item_r.camera);
  assign cam_idx  = cam_ext[CW-1:0];
  assign cam_ok   = int'(item_r.camera) < NUM_CAMERAS;
  assign cnt_ext  = CIW'(cnt_r);
  assign rd_total = pass2_r ? KW'(NUM_CAMERAS) : KW'(2 * NUM_CAMERAS);
  assign rd_cam   = pass2_r ? rd_cnt_r[CW-1:0] : rd_cnt_r[CW:1];
  assign rd_is_tail = !pass2_r && rd_cnt_r[0];

  assign mn_tol   = {1'b0, mn_r} + (SW+1)'(tol_r);
  assign mint_tol = {1'b0, mint_r} + (SW+1)'(tol_r);
  assign mx_e     = {1'b0, mx_r};
  assign hd_tol   = {1'b0, head_st_r[cnt_r]} + (SW+1)'(tol_r);
  assign tl_tol   = {1'b0, tail_st_r[cnt_r]} + (SW+1)'(tol_r);
  assign mid_sum  = {1'b0, mn_r} + {1'b0, mx_r};

  assign drop_pop   = c1_r && (hd_tol < mx_e);
  assign fill_after = drop_pop ? fill_r[cnt_r] - FW'(1) : fill_r[cnt_r];

  always_comb begin
    any_empty = 1'b0;
    for (int c = 0; c < NUM_CAMERAS; c++) begin
      if (fill_r[c] == '0) begin
        any_empty = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    pass2_nxt     = pass2_r;
    c1_nxt        = c1_r;
    c2_nxt        = c2_r;
    cnt_nxt       = cnt_r;
    rd_cnt_nxt    = rd_cnt_r;
    cap_v_nxt     = 1'b0;
    cap_tail_nxt  = cap_tail_r;
    cap_last_nxt  = cap_last_r;
    cap_cam_nxt   = cap_cam_r;
    mn_nxt        = mn_r;
    mx_nxt        = mx_r;
    mint_nxt      = mint_r;
    sync_nxt      = sync_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    head_ptr_nxt  = head_ptr_r;
    tail_ptr_nxt  = tail_ptr_r;
    fill_nxt      = fill_r;
    head_st_nxt   = head_st_r;
    head_tag_nxt  = head_tag_r;
    tail_st_nxt   = tail_st_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          pass2_nxt = 1'b0;
          state_nxt = (in_data.command == mqta_pkg::CMD_SYNC) ? S_EMPTY : S_PUSH;
        end
      end
      S_PUSH: begin
        if (ofree) begin
          out_valid_nxt         = 1'b1;
          out_nxt               = '0;
          out_nxt.source_camera = item_r.camera;
          out_nxt.last          = 1'b1;
          out_nxt.status        = mqta_pkg::ST_PUSH_FULL;
          if (cam_ok && fill_r[cam_idx] < FW'(QUEUE_DEPTH)) begin
            mem_we                = 1'b1;
            mem_waddr             = qaddr(cam_idx, tail_ptr_r[cam_idx]);
            mem_wdata             = {item_r.stamp, item_r.tag};
            tail_ptr_nxt[cam_idx] = ptr_inc(tail_ptr_r[cam_idx]);
            fill_nxt[cam_idx]     = fill_r[cam_idx] + FW'(1);
            out_nxt.status        = mqta_pkg::ST_PUSH_OK;
          end
          state_nxt = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (any_empty) begin
          state_nxt = S_FAIL;
        end else begin
          rd_cnt_nxt = '0;
          mn_nxt     = '1;
          mx_nxt     = '0;
          mint_nxt   = '1;
          state_nxt  = S_RD;
        end
      end
      S_RD: begin
        if (rd_cnt_r < rd_total) begin
          mem_raddr    = qaddr(rd_cam, rd_is_tail ? ptr_dec(tail_ptr_r[rd_cam])
                                                  : head_ptr_r[rd_cam]);
          cap_v_nxt    = 1'b1;
          cap_cam_nxt  = rd_cam;
          cap_tail_nxt = rd_is_tail;
          cap_last_nxt = (rd_cnt_r == rd_total - KW'(1));
          rd_cnt_nxt   = rd_cnt_r + KW'(1);
        end
        if (cap_v_r) begin
          if (cap_tail_r) begin
            tail_st_nxt[cap_cam_r] = rd_stamp;
            if (rd_stamp < mint_r) begin
              mint_nxt = rd_stamp;
            end
          end else begin
            head_st_nxt[cap_cam_r]  = rd_stamp;
            head_tag_nxt[cap_cam_r] = rd_tag;
            if (rd_stamp < mn_r) begin
              mn_nxt = rd_stamp;
            end
            if (rd_stamp > mx_r) begin
              mx_nxt = rd_stamp;
            end
          end
          if (cap_last_r) begin
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        sync_nxt = mid_sum[SW:1];
        cnt_nxt  = '0;
        if (pass2_r) begin
          state_nxt = (mn_tol > mx_e) ? S_EMIT : S_FAIL;
        end else begin
          c1_nxt    = mx_e > mn_tol;
          c2_nxt    = mint_tol < mx_e;
          state_nxt = ((mx_e > mn_tol) || (mint_tol < mx_e)) ? S_DROP : S_EMIT;
        end
      end
      S_DROP: begin
        if (drop_pop) begin
          head_ptr_nxt[cnt_r] = ptr_inc(head_ptr_r[cnt_r]);
          fill_nxt[cnt_r]     = fill_after;
        end
        if (c2_r && fill_after != '0 && tl_tol < mx_e) begin
          head_ptr_nxt[cnt_r] = tail_ptr_r[cnt_r];
          fill_nxt[cnt_r]     = '0;
        end
        if (cnt_r == CW'(NUM_CAMERAS - 1)) begin
          pass2_nxt = 1'b1;
          state_nxt = S_EMPTY;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_EMIT: begin
        if (ofree) begin
          out_valid_nxt         = 1'b1;
          out_nxt.status        = mqta_pkg::ST_SYNC_ITEM;
          out_nxt.source_camera = cnt_ext[1:0];
          out_nxt.entry_stamp   = head_st_r[cnt_r];
          out_nxt.entry_tag     = head_tag_r[cnt_r];
          out_nxt.sync_stamp    = sync_r;
          out_nxt.last          = (cnt_r == CW'(NUM_CAMERAS - 1));
          head_ptr_nxt[cnt_r]   = ptr_inc(head_ptr_r[cnt_r]);
          fill_nxt[cnt_r]       = fill_r[cnt_r] - FW'(1);
          if (cnt_r == CW'(NUM_CAMERAS - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      S_FAIL: begin
        if (ofree) begin
          out_valid_nxt  = 1'b1;
          out_nxt        = '0;
          out_nxt.status = mqta_pkg::ST_SYNC_FAIL;
          out_nxt.last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cap_v_r     <= 1'b0;
      tol_r       <= mqta_pkg::TOL_RESET;
      for (int c = 0; c < NUM_CAMERAS; c++) begin
        head_ptr_r[c] <= '0;
        tail_ptr_r[c] <= '0;
        fill_r[c]     <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cap_v_r     <= cap_v_nxt;
      if (cfg_valid && cfg_ready) begin
        tol_r <= cfg_data;
      end
      head_ptr_r <= head_ptr_nxt;
      tail_ptr_r <= tail_ptr_nxt;
      fill_r     <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    pass2_r    <= pass2_nxt;
    c1_r       <= c1_nxt;
    c2_r       <= c2_nxt;
    cnt_r      <= cnt_nxt;
    rd_cnt_r   <= rd_cnt_nxt;
    cap_tail_r <= cap_tail_nxt;
    cap_last_r <= cap_last_nxt;
    cap_cam_r  <= cap_cam_nxt;
    mn_r       <= mn_nxt;
    mx_r       <= mx_nxt;
    mint_r     <= mint_nxt;
    sync_r     <= sync_nxt;
    out_r      <= out_nxt;
    head_st_r  <= head_st_nxt;
    head_tag_r <= head_tag_nxt;
    tail_st_r  <= tail_st_nxt;
  end

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (fill_r[cnt_r] != '0))
    else $error("sync emit from an empty queue");

  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (fill_r[cam_idx] < FW'(QUEUE_DEPTH)))
    else $error("push written into a full queue");

  a_capture_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    cap_v_r |-> (state_r == S_RD))
    else $error("read data captured outside the read sweep");

  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == mqta_pkg::ST_SYNC_FAIL) |-> out_r.last)
    else $error("failed sync result not marked last");

endmodule

// ===== bench/multi_queue_timestamp_aligner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-queue timestamp aligner testbench
// Drives push and sync requests through the aligner with random bursts and
// output stalls, predicts every result from a behavioural copy of the camera
// queues and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module multi_queue_timestamp_aligner_tb;

  localparam int NCAM    = 4;
  localparam int QDEPTH  = 16;
  localparam int WD_LIMIT = 4000;
  localparam int IN_W    = $bits(mqta_pkg::in_item_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mqta_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mqta_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mqta_pkg::TOL_W-1:0] cfg_data = '0;

  multi_queue_timestamp_aligner #(.NUM_CAMERAS(NCAM), .QUEUE_DEPTH(QDEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Behavioural copy of the camera queues.
  logic [mqta_pkg::STAMP_W-1:0] cam_stamps [NCAM][QDEPTH];
  logic [mqta_pkg::TAG_W-1:0]   cam_tags   [NCAM][QDEPTH];
  int unsigned        cam_head [NCAM];
  int unsigned        cam_tail [NCAM];
  int unsigned        cam_fill [NCAM];
  logic [63:0]        tol_us;

  mqta_pkg::out_item_t pending_results [$];
  int  error_count = 0;
  int  idle_cycles = 0;
  int  result_count = 0;
  int  sync_hits = 0;
  int  sync_misses = 0;
  int  full_refusals = 0;
  bit  gaps_on = 1'b1;
  bit  hold_off = 1'b0;
  logic [mqta_pkg::STAMP_W-1:0] clock_us = '0;

  function automatic mqta_pkg::out_item_t make_result(logic [1:0] st, logic [1:0] cam,
      logic [mqta_pkg::STAMP_W-1:0] es, logic [mqta_pkg::TAG_W-1:0] et,
      logic [mqta_pkg::STAMP_W-1:0] ss, logic lst);
    mqta_pkg::out_item_t r;
    r.status = st; r.source_camera = cam; r.entry_stamp = es;
    r.entry_tag = et; r.sync_stamp = ss; r.last = lst;
    return r;
  endfunction

  function automatic void expect_result(mqta_pkg::out_item_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic logic [63:0] head_stamp(int c);
    return {16'd0, cam_stamps[c][cam_head[c]]};
  endfunction

  function automatic logic [63:0] tail_stamp(int c);
    return {16'd0, cam_stamps[c][(cam_tail[c] + QDEPTH - 1) % QDEPTH]};
  endfunction

  function automatic bit some_queue_empty();
    for (int c = 0; c < NCAM; c++) if (cam_fill[c] == 0) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void pop_head(int c);
    if (cam_fill[c] != 0) begin
      cam_head[c] = (cam_head[c] + 1) % QDEPTH;
      cam_fill[c]--;
    end
  endfunction

  function automatic void head_span(output logic [63:0] lo, output logic [63:0] hi);
    lo = '1; hi = '0;
    for (int c = 0; c < NCAM; c++) begin
      if (head_stamp(c) < lo) lo = head_stamp(c);
      if (head_stamp(c) > hi) hi = head_stamp(c);
    end
  endfunction

  function automatic void predict_alignment(mqta_pkg::in_item_t req);
    logic [63:0] lo, hi, tail_lo, mid;
    bit recheck;
    mqta_pkg::out_item_t fail;
    if (req.command == mqta_pkg::CMD_PUSH) begin
      if (cam_fill[req.camera] >= QDEPTH) begin
        expect_result(make_result(mqta_pkg::ST_PUSH_FULL, req.camera, '0, '0, '0, 1'b1));
        full_refusals++;
      end else begin
        cam_stamps[req.camera][cam_tail[req.camera]] = req.stamp;
        cam_tags[req.camera][cam_tail[req.camera]] = req.tag;
        cam_tail[req.camera] = (cam_tail[req.camera] + 1) % QDEPTH;
        cam_fill[req.camera]++;
        expect_result(make_result(mqta_pkg::ST_PUSH_OK, req.camera, '0, '0, '0, 1'b1));
      end
      return;
    end
    fail = make_result(mqta_pkg::ST_SYNC_FAIL, '0, '0, '0, '0, 1'b1);
    if (some_queue_empty()) begin
      expect_result(fail); sync_misses++; return;
    end
    head_span(lo, hi);
    tail_lo = '1;
    recheck = 1'b0;
    for (int c = 0; c < NCAM; c++) if (tail_stamp(c) < tail_lo) tail_lo = tail_stamp(c);
    if (hi > lo + tol_us) begin
      recheck = 1'b1;
      for (int c = 0; c < NCAM; c++) if (head_stamp(c) + tol_us < hi) pop_head(c);
    end
    if (tail_lo + tol_us < hi) begin
      recheck = 1'b1;
      for (int c = 0; c < NCAM; c++)
        if (cam_fill[c] != 0 && tail_stamp(c) + tol_us < hi) begin
          cam_head[c] = cam_tail[c];
          cam_fill[c] = 0;
        end
    end
    if (recheck) begin
      if (some_queue_empty()) begin
        expect_result(fail); sync_misses++; return;
      end
      head_span(lo, hi);
      if (!(lo + tol_us > hi)) begin
        expect_result(fail); sync_misses++; return;
      end
    end
    mid = (lo + hi) >> 1;
    for (int c = 0; c < NCAM; c++) begin
      expect_result(make_result(mqta_pkg::ST_SYNC_ITEM, c[1:0], cam_stamps[c][cam_head[c]],
                                cam_tags[c][cam_head[c]], mid[mqta_pkg::STAMP_W-1:0],
                                c == NCAM - 1));
      pop_head(c);
    end
    sync_hits++;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      mqta_pkg::out_item_t want;
      result_count++;
      if (pending_results.size() == 0) begin
        $error("unexpected result %p", out_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          error_count++;
        end
        if (out_data.source_camera !== want.source_camera) begin
          $error("source_camera: expected %0d, got %0d", want.source_camera,
                 out_data.source_camera);
          error_count++;
        end
        if (out_data.entry_stamp !== want.entry_stamp) begin
          $error("entry_stamp: expected %0h, got %0h", want.entry_stamp, out_data.entry_stamp);
          error_count++;
        end
        if (out_data.entry_tag !== want.entry_tag) begin
          $error("entry_tag: expected %0h, got %0h", want.entry_tag, out_data.entry_tag);
          error_count++;
        end
        if (out_data.sync_stamp !== want.sync_stamp) begin
          $error("sync_stamp: expected %0h, got %0h", want.sync_stamp, out_data.sync_stamp);
          error_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          error_count++;
        end
      end
    end
  end

  // The receiver stalls on its own pattern; a long hold-off can be requested.
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (!gaps_on) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 9) < 3);
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WD_LIMIT) begin
      $display("[multi_queue_timestamp_aligner] ERROR");
      $finish;
    end
  end

  int burst_left = 0;

  task automatic send_request(mqta_pkg::in_item_t req);
    int gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 8);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_alignment(req);
  endtask

  task automatic push_entry(int cam, logic [mqta_pkg::STAMP_W-1:0] st,
                            logic [mqta_pkg::TAG_W-1:0] tg);
    mqta_pkg::in_item_t r;
    r.command = mqta_pkg::CMD_PUSH; r.camera = cam[1:0]; r.stamp = st; r.tag = tg;
    send_request(r);
  endtask

  task automatic request_sync();
    mqta_pkg::in_item_t r;
    r.command = mqta_pkg::CMD_SYNC; r.camera = 2'($urandom);
    r.stamp = mqta_pkg::STAMP_W'({$urandom, $urandom});
    r.tag = 16'($urandom);
    send_request(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [mqta_pkg::TOL_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tol_us = {32'd0, value};
  endtask

  task automatic test_directed_extremes();
    request_sync();
    for (int c = 0; c < NCAM; c++) push_entry(c, 48'd1000 + c, 16'(16'hffff - c));
    request_sync();
    for (int k = 0; k < QDEPTH + 1; k++) push_entry(2, 48'd5000 + k, 16'(k));
    request_sync();
    push_entry(0, '1, '1);
    push_entry(1, '0, '0);
    request_sync();
  endtask

  task automatic test_stale_drops();
    write_tolerance(32'd0);
    for (int c = 0; c < NCAM; c++) push_entry(c, 48'd100000, 16'(c));
    request_sync();
    push_entry(0, 48'd10, 16'h1); push_entry(0, 48'd200000, 16'h2);
    for (int c = 1; c < NCAM; c++) push_entry(c, 48'd200000, 16'(c));
    request_sync();
    write_tolerance(32'hffffffff);
    for (int c = 0; c < NCAM; c++) push_entry(c, 48'hffff_0000_0000 + c, 16'(c));
    request_sync();
    write_tolerance(32'd40000);
  endtask

  task automatic random_rounds(int n_items, int spread);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        for (int c = 0; c < NCAM && sent < n_items; c++) begin
          clock_us = clock_us + $urandom_range(0, 3000);
          push_entry($urandom_range(0, 3), clock_us + $urandom_range(0, spread),
                     16'($urandom));
          sent++;
        end
        request_sync(); sent++;
      end else begin
        mqta_pkg::in_item_t r;
        r = mqta_pkg::in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
        send_request(r); sent++;
      end
    end
  endtask

  task automatic test_back_pressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      random_rounds(20, 50000);
    join
    drain();
  endtask

  task automatic test_random_mix();
    write_tolerance(32'd20000);
    random_rounds(60, 40000);
    gaps_on = 1'b0;
    random_rounds(40, 10000);
    gaps_on = 1'b1;
    write_tolerance(32'd40000);
    random_rounds(80, 90000);
  endtask

  initial begin
    for (int c = 0; c < NCAM; c++) begin
      cam_head[c] = 0; cam_tail[c] = 0; cam_fill[c] = 0;
    end
    tol_us = {32'd0, mqta_pkg::TOL_RESET};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_stale_drops();
    test_back_pressure();
    test_random_mix();
    drain();
    $display("Covered %0d results: %0d aligned syncs, %0d failed syncs, %0d refused pushes.",
             result_count, sync_hits, sync_misses, full_refusals);
    $display("Tolerance settings included zero, the maximum and the reset value.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("[multi_queue_timestamp_aligner] OK");
    end else begin
      $display("[multi_queue_timestamp_aligner] ERROR");
    end
    $finish;
  end

endmodule
